/* design/all_pairs_shortest_path_core_macros.svh */
// assertion macros used by the checker file
`ifndef ALL_PAIRS_SHORTEST_PATH_CORE_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATH_CORE_MACROS_SVH

// property checked only outside reset
`define APSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define APSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/apsp_pkg.sv */
`default_nettype none

package apsp_pkg;

    localparam int DEFAULT_MAX_VERTICES = 64;

    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 6;
    localparam int WEIGHT_W = 17;
    localparam int DIST_W   = 32;
    localparam int VIA_W    = 7;
    localparam int VC_W     = 7;

    localparam logic [VC_W-1:0]   VC_RESET = 7'd64;
    localparam logic [VIA_W-1:0]  VIA_NONE = {VIA_W{1'b1}};

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic rst_sweep;
        logic wr_weight;
        logic rd_pair;
        logic idx_clear;
        logic via_clear;
        logic rd_ik_kj;
        logic rd_ij;
        logic relax_wr;
        logic flag_clr;
        logic load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic              rst_last;
        logic              n_zero;
        logic              ij_last;
        logic              kij_last;
        logic              neg_hit;
        logic              out_free;
        logic [FUNC_W-1:0] func;
    } t_status;

endpackage

`default_nettype wire

/* design/all_pairs_shortest_path_core.sv */
// floyd-warshall all-pairs shortest path engine over a dense weight matrix of up to
// MAX_VERTICES vertices, held in on-chip distance and via memories. each request carries a
// func code: write stores one weight, run relaxes every k, i, j over the configured vertex
// count, read returns one pair's distance and last intermediate vertex; every request
// answers with exactly one result, which also reports the negative-cycle flag of the last
// run. write and read codes pass through capture, memory access and result load, unused
// codes through capture, decode and result load. a run passes through capture and decode,
// one via-clear write per pair, then for each relaxation the steps set by the two read
// ports of the distance memory (d[i][k] and d[k][j] together, then d[i][j], then the
// compare and write-back), and result load; a negative diagonal ends it early. after reset
// the via memory is swept to -1, one entry a cycle, over all 4**ceil(log2(MAX_VERTICES))
// entries (4096 at the default), while input stays stalled; the vertex_count register may
// be written at any time it is idle, including during that sweep.
`default_nettype none

module all_pairs_shortest_path_core import apsp_pkg::*; #(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: vertex count register
    input  logic                       i_cfg_we,
    input  logic [VC_W-1:0]            i_cfg_wdata,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic [IDX_W-1:0]           i_row,
    input  logic [IDX_W-1:0]           i_col,
    input  logic signed [WEIGHT_W-1:0] i_weight,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [DIST_W-1:0]   o_distance,
    output logic signed [VIA_W-1:0]    o_via_vertex,
    output logic                       o_negative_cycle
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: reset sweep, request decode, via clear and the k/i/j relaxation loop
    apsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // memories, loop counters, saturating adder, compare and result register
    apsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_func           (i_func),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_weight         (i_weight),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_distance       (o_distance),
        .o_via_vertex     (o_via_vertex),
        .o_negative_cycle (o_negative_cycle)
    );

endmodule

`default_nettype wire

/* design/apsp_ctrl.sv */
`default_nettype none

module apsp_ctrl import apsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_VCLR  = 8'b0000_1000,
        S_RD1   = 8'b0001_0000,
        S_RD2   = 8'b0010_0000,
        S_WR    = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.rst_sweep = 1'b1;
                if (i_status.rst_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (i_status.func)
                    FUNC_WRITE: o_cmd.wr_weight = 1'b1;
                    FUNC_READ:  o_cmd.rd_pair   = 1'b1;
                    FUNC_RUN: begin
                        o_cmd.flag_clr  = 1'b1;
                        o_cmd.idx_clear = 1'b1;
                        if (!i_status.n_zero) n_state = S_VCLR;
                    end
                    default: ;
                endcase
            end
            S_VCLR: begin
                // counters wrap to zero on the last entry, ready for k = i = j = 0
                o_cmd.via_clear = 1'b1;
                if (i_status.ij_last) n_state = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_ik_kj = 1'b1;
                n_state        = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_ij = 1'b1;
                n_state     = S_WR;
            end
            S_WR: begin
                o_cmd.relax_wr = 1'b1;
                if (i_status.neg_hit || i_status.kij_last) n_state = S_DONE;
                else n_state = S_RD1;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

endmodule

`default_nettype wire

/* design/apsp_datapath.sv */
`default_nettype none

module apsp_datapath import apsp_pkg::*; #(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [VC_W-1:0]            i_cfg_wdata,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic [IDX_W-1:0]           i_row,
    input  logic [IDX_W-1:0]           i_col,
    input  logic signed [WEIGHT_W-1:0] i_weight,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic signed [DIST_W-1:0]   o_distance,
    output logic signed [VIA_W-1:0]    o_via_vertex,
    output logic                       o_negative_cycle
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = $clog2(MAX_VERTICES + 1);

    logic [VC_W-1:0]     r_vc;
    logic [FUNC_W-1:0]   r_func;
    logic [IDX_W-1:0]    r_row, r_col;
    logic [WEIGHT_W-1:0] r_weight;
    logic                r_in_range;
    logic [AW-1:0]       r_clr;
    logic [VW-1:0]       r_i, r_j, r_k;
    logic [DIST_W-1:0]   r_qa, r_qb, r_cand;
    logic [VIA_W-1:0]    r_qv;
    logic                r_flag;
    logic                r_out_valid;
    logic [DIST_W-1:0]   r_distance;
    logic [VIA_W-1:0]    r_via;
    logic                r_neg;

    logic [DIST_W-1:0]   r_dist_mem [DEPTH];
    logic [VIA_W-1:0]    r_via_mem  [DEPTH];

    logic [NW-1:0]       w_n, w_n_m1;
    logic                w_i_last, w_j_last, w_k_last, w_ij_last;
    logic [AW-1:0]       w_pair, w_ik, w_kj, w_ij, w_addr_a;
    logic                w_rd_en;
    logic [DIST_W:0]     w_sum;
    logic [DIST_W-1:0]   w_sat;
    logic                w_improve, w_neg_hit, w_out_free;
    logic                w_dist_we, w_via_we;
    logic [AW-1:0]       w_dist_waddr, w_via_waddr;
    logic [DIST_W-1:0]   w_dist_wdata;
    logic [VIA_W-1:0]    w_via_wdata;

    // vertex count saturated to the store size
    assign w_n    = (32'(r_vc) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(r_vc);
    assign w_n_m1 = w_n - NW'(1);

    assign w_i_last  = (NW'(r_i) == w_n_m1);
    assign w_j_last  = (NW'(r_j) == w_n_m1);
    assign w_k_last  = (NW'(r_k) == w_n_m1);
    assign w_ij_last = w_i_last && w_j_last;

    assign w_pair = {VW'(r_row), VW'(r_col)};
    assign w_ik   = {r_i, r_k};
    assign w_kj   = {r_k, r_j};
    assign w_ij   = {r_i, r_j};

    // saturating sum of d[i][k] and d[k][j]
    assign w_sum = {r_qa[DIST_W-1], r_qa} + {r_qb[DIST_W-1], r_qb};
    always_comb begin
        if (w_sum[DIST_W] != w_sum[DIST_W-1])
            w_sat = w_sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
        else
            w_sat = w_sum[DIST_W-1:0];
    end

    assign w_improve = $signed(r_cand) < $signed(r_qa);
    assign w_neg_hit = w_improve && (r_i == r_j) && r_cand[DIST_W-1];
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_status.rst_last = &r_clr;
    assign o_status.n_zero   = (w_n == '0);
    assign o_status.ij_last  = w_ij_last;
    assign o_status.kij_last = w_ij_last && w_k_last;
    assign o_status.neg_hit  = w_neg_hit;
    assign o_status.out_free = w_out_free;
    assign o_status.func     = r_func;

    // read port a address
    always_comb begin
        if (i_cmd.rd_ik_kj) w_addr_a = w_ik;
        else if (i_cmd.rd_ij) w_addr_a = w_ij;
        else w_addr_a = w_pair;
    end
    assign w_rd_en = i_cmd.rd_pair || i_cmd.rd_ik_kj || i_cmd.rd_ij;

    // distance write port
    assign w_dist_we    = (i_cmd.wr_weight && r_in_range) || (i_cmd.relax_wr && w_improve);
    assign w_dist_waddr = i_cmd.wr_weight ? w_pair : w_ij;
    assign w_dist_wdata = i_cmd.wr_weight
                        ? {{(DIST_W-WEIGHT_W){r_weight[WEIGHT_W-1]}}, r_weight}
                        : r_cand;

    // via write port
    always_comb begin
        w_via_we    = 1'b0;
        w_via_waddr = w_ij;
        w_via_wdata = VIA_NONE;
        if (i_cmd.rst_sweep) begin
            w_via_we    = 1'b1;
            w_via_waddr = r_clr;
        end else if (i_cmd.via_clear) begin
            w_via_we = 1'b1;
        end else if (i_cmd.relax_wr && w_improve && !w_neg_hit) begin
            w_via_we    = 1'b1;
            w_via_wdata = VIA_W'(r_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dist_we) r_dist_mem[w_dist_waddr] <= w_dist_wdata;
        if (w_rd_en) begin
            r_qa <= r_dist_mem[w_addr_a];
            r_qb <= r_dist_mem[w_kj];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_via_we) r_via_mem[w_via_waddr] <= w_via_wdata;
        if (i_cmd.rd_pair) r_qv <= r_via_mem[w_pair];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_ij) r_cand <= w_sat;
        if (i_cmd.capture) begin
            r_func     <= i_func;
            r_row      <= i_row;
            r_col      <= i_col;
            r_weight   <= i_weight;
            r_in_range <= (32'(i_row) < MAX_VERTICES) && (32'(i_col) < MAX_VERTICES);
        end
        if (i_cmd.load_out) begin
            r_neg <= r_flag;
            if (r_func == FUNC_READ && r_in_range) begin
                r_distance <= r_qa;
                r_via      <= r_qv;
            end else begin
                r_distance <= '0;
                r_via      <= VIA_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc        <= VC_RESET;
            r_clr       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_vc <= i_cfg_wdata;
            if (i_cmd.rst_sweep) r_clr <= r_clr + AW'(1);

            if (i_cmd.idx_clear) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end else if (i_cmd.via_clear || i_cmd.relax_wr) begin
                r_j <= w_j_last ? '0 : r_j + VW'(1);
                if (w_j_last) r_i <= w_i_last ? '0 : r_i + VW'(1);
                if (i_cmd.relax_wr && w_ij_last) r_k <= w_k_last ? '0 : r_k + VW'(1);
            end

            if (i_cmd.flag_clr) r_flag <= 1'b0;
            else if (i_cmd.relax_wr && w_neg_hit) r_flag <= 1'b1;

            r_out_valid <= i_cmd.load_out || (r_out_valid && i_out_stall);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_distance       = r_distance;
    assign o_via_vertex     = r_via;
    assign o_negative_cycle = r_neg;

endmodule

`default_nettype wire

/* design/apsp_checker.sv */
`default_nettype none
`include "all_pairs_shortest_path_core_macros.svh"

module apsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_distance,
    input wire logic [6:0]  o_via_vertex,
    input wire logic        o_negative_cycle
);

    // a held result stays offered
    `APSP_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")

    // a held result keeps its payload
    `APSP_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_distance) && $stable(o_via_vertex) && $stable(o_negative_cycle), "result changed while stalled")

    // one request at a time: the engine is busy right after taking one
    `APSP_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "second request taken back to back")

    // reset leaves no result pending
    `APSP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind all_pairs_shortest_path_core apsp_checker u_apsp_checker (.*);

`default_nettype wire

/* dv/all_pairs_shortest_path_core_tb.sv */
`timescale 1ns / 1ps

module all_pairs_shortest_path_core_tb;
    import apsp_pkg::*;

    localparam int MAX_V       = DEFAULT_MAX_VERTICES;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 300;
    localparam int TARGET_REQS = 1400;
    localparam int NO_EDGE     = 65535;
    localparam longint DIST_HI = 64'sd2147483647;
    localparam longint DIST_LO = -64'sd2147483648;

    // func code the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0]           func;
        logic [IDX_W-1:0]            row;
        logic [IDX_W-1:0]            col;
        logic signed [WEIGHT_W-1:0]  weight;
    } t_apsp_req;

    typedef struct {
        logic signed [DIST_W-1:0] dist_val;
        logic signed [VIA_W-1:0]  via;
        logic                     neg;
    } t_answer;

    // one directed row: request plus an optional typed-in answer
    typedef struct {
        t_apsp_req req;
        bit        pinned;
        t_answer   ans;
    } t_step;

    // dut ports
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [VC_W-1:0]             i_cfg_wdata = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [FUNC_W-1:0]           i_func = FUNC_WRITE;
    logic [IDX_W-1:0]            i_row = '0;
    logic [IDX_W-1:0]            i_col = '0;
    logic signed [WEIGHT_W-1:0]  i_weight = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [DIST_W-1:0]    o_distance;
    logic signed [VIA_W-1:0]     o_via_vertex;
    logic                        o_negative_cycle;

    // shadow of the block: distance and via memories, cycle flag, vertex count
    logic signed [DIST_W-1:0] dist_mem [MAX_V*MAX_V];
    logic signed [VIA_W-1:0]  via_mem  [MAX_V*MAX_V];
    bit                       filled   [MAX_V*MAX_V];
    int                       filled_idx [$];
    logic                     cycle_seen;
    logic [VC_W-1:0]          vertices_cfg;

    // answers owed by the block, oldest first
    t_answer pending_answers [$];
    t_answer due;

    int  mismatches = 0;
    int  live_reqs = 0;
    int  burst_left = 0;
    int  cycle_count = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    t_step dir_steps [23];

    all_pairs_shortest_path_core #(
        .MAX_VERTICES (MAX_V)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_weight         (i_weight),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_distance       (o_distance),
        .o_via_vertex     (o_via_vertex),
        .o_negative_cycle (o_negative_cycle)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // floyd-warshall relaxation in place over the vertices in use
    function automatic void relax_all();
        int n, i, j, k;
        longint s;
        logic signed [DIST_W-1:0] cand;
        n = (int'(vertices_cfg) > MAX_V) ? MAX_V : int'(vertices_cfg);
        cycle_seen = 1'b0;
        for (i = 0; i < n; i++)
            for (j = 0; j < n; j++)
                via_mem[i*MAX_V+j] = VIA_NONE;
        for (k = 0; k < n; k++)
            for (i = 0; i < n; i++)
                for (j = 0; j < n; j++) begin
                    s = longint'(dist_mem[i*MAX_V+k]) + longint'(dist_mem[k*MAX_V+j]);
                    // sums clip at the 32-bit signed limits
                    if (s > DIST_HI)
                        cand = DIST_W'(DIST_HI);
                    else if (s < DIST_LO)
                        cand = DIST_W'(DIST_LO);
                    else
                        cand = DIST_W'(s);
                    if (cand < dist_mem[i*MAX_V+j]) begin
                        dist_mem[i*MAX_V+j] = cand;
                        // negative diagonal ends the run, no via recorded
                        if (i == j && cand < 0) begin
                            cycle_seen = 1'b1;
                            return;
                        end
                        via_mem[i*MAX_V+j] = VIA_W'(k);
                    end
                end
    endfunction

    // answer the block owes for one request, shadow state updated
    function automatic t_answer answer_for(input t_apsp_req r);
        t_answer a;
        int idx;
        idx = int'(r.row) * MAX_V + int'(r.col);
        a.dist_val = '0;
        a.via      = VIA_NONE;
        case (r.func)
            FUNC_WRITE: begin
                dist_mem[idx] = DIST_W'(r.weight);
                if (!filled[idx]) begin
                    filled[idx] = 1'b1;
                    filled_idx.push_back(idx);
                end
            end
            FUNC_RUN: relax_all();
            FUNC_READ: begin
                a.dist_val = dist_mem[idx];
                a.via      = via_mem[idx];
            end
            default: ;
        endcase
        a.neg = cycle_seen;
        return a;
    endfunction

    function automatic t_apsp_req make_req(input logic [FUNC_W-1:0] f, input int row,
                                           input int col, input int w);
        t_apsp_req r;
        r.func   = f;
        r.row    = IDX_W'(row);
        r.col    = IDX_W'(col);
        r.weight = WEIGHT_W'(w);
        return r;
    endfunction

    // weights: mostly small, some no-edge, negatives only when allowed
    function automatic int pick_weight(input bit neg_ok);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom_range(0, 50);
        if (sel < 6)
            return NO_EDGE;
        if (sel < 8)
            return neg_ok ? -int'($urandom_range(1, 20)) : int'($urandom_range(51, 5000));
        if (sel == 8)
            return neg_ok ? int'($urandom_range(0, 98303)) - 32768 : int'($urandom_range(0, 65535));
        // raw 17-bit pattern, down to -65536
        return neg_ok ? int'($urandom_range(0, 131071)) : int'($urandom_range(0, 65535));
    endfunction

    // offer one request, wait for it to be taken, then maybe idle a while
    task automatic send_request(input t_apsp_req r, input bit pinned, input t_answer pinned_ans);
        t_answer a;
        int gap;
        i_in_valid <= 1'b1;
        i_func     <= r.func;
        i_row      <= r.row;
        i_col      <= r.col;
        i_weight   <= r.weight;
        do @(posedge i_clk); while (o_in_stall);
        a = answer_for(r);
        pending_answers.push_back(pinned ? pinned_ans : a);
        live_reqs++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop offering and wait for every owed answer
    task automatic drain_answers();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_vertices(input logic [VC_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        vertices_cfg = v;
    endtask

    // result side: own stall pattern, plus one long hold-off on request
    initial begin : out_pacing
        int span, mode, tick;
        tick = 0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                // long hold so the block backs up into its input
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(1, 40);
                repeat (span) begin
                    case (mode)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= 1'($urandom_range(0, 1));
                        2:       i_out_stall <= 1'b1;
                        default: i_out_stall <= (tick % 3 == 0);
                    endcase
                    tick++;
                    @(posedge i_clk);
                end
            end
        end
    end

    // compare every accepted result with the oldest owed answer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                $error("result with no request waiting: distance %0d via %0d",
                       o_distance, o_via_vertex);
                mismatches++;
            end else begin
                due = pending_answers.pop_front();
                if (o_distance !== due.dist_val) begin
                    $error("distance: expected %0d, got %0d", due.dist_val, o_distance);
                    mismatches++;
                end
                if (o_via_vertex !== due.via) begin
                    $error("via_vertex: expected %0d, got %0d", due.via, o_via_vertex);
                    mismatches++;
                end
                if (o_negative_cycle !== due.neg) begin
                    $error("negative_cycle: expected %0d, got %0d", due.neg, o_negative_cycle);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int phase, vc, n, i, j, op, extras, idx;
        bit neg_ok;
        t_answer blank;

        blank = '{32'sd0, VIA_NONE, 1'b0};
        for (i = 0; i < MAX_V * MAX_V; i++) begin
            dist_mem[i] = '0;
            via_mem[i]  = VIA_NONE;
            filled[i]   = 1'b0;
        end
        cycle_seen   = 1'b0;
        vertices_cfg = VC_RESET;

        // directed rows on a three-vertex graph; writes answer zero, reads of
        // fresh writes answer the weight, runs and later reads go to the shadow
        dir_steps[0]  = '{'{FUNC_SPARE, 6'd63, 6'd0,  -17'sd1},     1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[1]  = '{'{FUNC_WRITE, 6'd0,  6'd0,  17'sd0},      1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[2]  = '{'{FUNC_WRITE, 6'd0,  6'd1,  17'sd65535},  1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[3]  = '{'{FUNC_WRITE, 6'd0,  6'd2,  17'sd7},      1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[4]  = '{'{FUNC_WRITE, 6'd1,  6'd0,  -17'sd32768}, 1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[5]  = '{'{FUNC_WRITE, 6'd1,  6'd1,  17'sd0},      1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[6]  = '{'{FUNC_WRITE, 6'd1,  6'd2,  17'sd65535},  1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[7]  = '{'{FUNC_WRITE, 6'd2,  6'd0,  17'sd3},      1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[8]  = '{'{FUNC_WRITE, 6'd2,  6'd1,  17'sd1},      1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[9]  = '{'{FUNC_WRITE, 6'd2,  6'd2,  17'sd0},      1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[10] = '{'{FUNC_READ,  6'd0,  6'd1,  17'sd0},      1'b1,
                          '{32'sd65535, VIA_NONE, 1'b0}};
        dir_steps[11] = '{'{FUNC_READ,  6'd1,  6'd0,  -17'sd1},     1'b1,
                          '{-32'sd32768, VIA_NONE, 1'b0}};
        dir_steps[12] = '{'{FUNC_WRITE, 6'd63, 6'd63, -17'sd65536}, 1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[13] = '{'{FUNC_READ,  6'd63, 6'd63, 17'sd0},      1'b1,
                          '{-32'sd65536, VIA_NONE, 1'b0}};
        dir_steps[14] = '{'{FUNC_WRITE, 6'd42, 6'd21, 17'sd21845},  1'b1, '{32'sd0, VIA_NONE, 1'b0}};
        dir_steps[15] = '{'{FUNC_READ,  6'd42, 6'd21, 17'sd0},      1'b1,
                          '{32'sd21845, VIA_NONE, 1'b0}};
        dir_steps[16] = '{'{FUNC_RUN,   6'd0,  6'd0,  17'sd0},      1'b0, blank};
        dir_steps[17] = '{'{FUNC_READ,  6'd2,  6'd0,  17'sd0},      1'b0, blank};
        dir_steps[18] = '{'{FUNC_READ,  6'd0,  6'd2,  17'sd0},      1'b0, blank};
        // second run starts from the first run's distances
        dir_steps[19] = '{'{FUNC_RUN,   6'd21, 6'd42, 17'sd65535},  1'b0, blank};
        dir_steps[20] = '{'{FUNC_READ,  6'd2,  6'd2,  17'sd0},      1'b0, blank};
        dir_steps[21] = '{'{FUNC_READ,  6'd0,  6'd0,  17'sd0},      1'b0, blank};
        dir_steps[22] = '{'{FUNC_SPARE, 6'd0,  6'd63, 17'sd43690},  1'b0, blank};

        // synchronous reset, then the vertex count while the via sweep runs
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_vertices(7'd3);

        foreach (dir_steps[s])
            send_request(dir_steps[s].req, dir_steps[s].pinned, dir_steps[s].ans);

        // random phases: each starts idle, sets a count, and for small counts
        // fills the whole matrix before running, so no unwritten entry is used
        phase = 0;
        while (live_reqs < TARGET_REQS) begin
            drain_answers();
            case (phase)
                0: vc = 1;
                1: vc = 64;
                2: vc = 127;
                3: vc = 0;
                5: vc = 6;
                default: begin
                    op = $urandom_range(0, 9);
                    if (op == 0)
                        vc = $urandom_range(64, 127);
                    else if (op == 1)
                        vc = 0;
                    else if (op == 2)
                        vc = $urandom_range(7, 12);
                    else
                        vc = $urandom_range(1, 6);
                end
            endcase
            set_vertices(VC_W'(vc));
            // one phase runs against a long result hold-off
            if (phase == 5)
                hold_req = 1'b1;
            n = vc;

            if (n >= 1 && n <= 12) begin
                neg_ok = 1'($urandom_range(0, 1));
                for (i = 0; i < n; i++)
                    for (j = 0; j < n; j++)
                        send_request(make_req(FUNC_WRITE, i, j,
                                              (i == j && $urandom_range(0, 7) != 0) ?
                                              0 : pick_weight(neg_ok)), 1'b0, blank);
                send_request(make_req(FUNC_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                                      $urandom_range(0, 131071)), 1'b0, blank);
            end else if (n == 0) begin
                // empty run only clears the cycle flag
                send_request(make_req(FUNC_RUN, 0, 0, 0), 1'b0, blank);
            end

            extras = $urandom_range(8, 30);
            repeat (extras) begin
                op = $urandom_range(0, 9);
                if (op == 6) begin
                    send_request(make_req(FUNC_SPARE, $urandom_range(0, 63),
                                          $urandom_range(0, 63), $urandom_range(0, 131071)),
                                 1'b0, blank);
                end else if (op == 7) begin
                    send_request(make_req(FUNC_WRITE, $urandom_range(0, 63),
                                          $urandom_range(0, 63), pick_weight(1'b1)),
                                 1'b0, blank);
                end else if (op == 8 && n <= 12) begin
                    send_request(make_req(FUNC_RUN, $urandom_range(0, 63),
                                          $urandom_range(0, 63), $urandom_range(0, 131071)),
                                 1'b0, blank);
                end else if (n >= 1 && n <= 12 && $urandom_range(0, 1) == 0) begin
                    send_request(make_req(FUNC_READ, $urandom_range(0, n - 1),
                                          $urandom_range(0, n - 1), $urandom_range(0, 131071)),
                                 1'b0, blank);
                end else begin
                    // read only entries that have been written
                    idx = filled_idx[$urandom_range(0, filled_idx.size() - 1)];
                    send_request(make_req(FUNC_READ, idx / MAX_V, idx % MAX_V,
                                          $urandom_range(0, 131071)), 1'b0, blank);
                end
            end
            phase++;
        end

        // all requests taken: collect the rest, then watch for strays
        drain_answers();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* all_pairs_shortest_path_core.f */
+incdir+design
design/apsp_pkg.sv
design/apsp_ctrl.sv
design/apsp_datapath.sv
design/all_pairs_shortest_path_core.sv
design/apsp_checker.sv
dv/all_pairs_shortest_path_core_tb.sv
